/* rtl/bvs_pkg.sv */
// Shared types, codes and constants of the bencode value skipper.
package bvs_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int LEN_WIDTH = 32;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int NEST_W    = 6;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] CHR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] CHR_E    = 8'h65;
    localparam logic [BYTE_W-1:0] CHR_I    = 8'h69;
    localparam logic [BYTE_W-1:0] CHR_L    = 8'h6c;
    localparam logic [BYTE_W-1:0] CHR_NUL  = 8'h00;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_ITEM = 5'b00010,
        MODE_LEN  = 5'b00100,
        MODE_STR  = 5'b01000,
        MODE_INT  = 5'b10000
    } t_mode;

    typedef enum logic [2:0] {
        ROLE_OPENER = 3'd0,
        ROLE_DIGIT  = 3'd1,
        ROLE_SEP    = 3'd2,
        ROLE_STRING = 3'd3,
        ROLE_INT    = 3'd4,
        ROLE_CLOSER = 3'd5,
        ROLE_TERM   = 3'd6
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_DEPTH     = 2'd1,
        ERR_LENGTH    = 2'd2,
        ERR_NUL_INT   = 2'd3
    } t_err;

    typedef struct packed {
        t_mode                mode;
        logic [DEPTH_W-1:0]   depth;
        logic [LEN_WIDTH-1:0] accum;
        logic [LEN_WIDTH-1:0] left;
    } t_state;

    typedef struct packed {
        logic              done;
        t_role             role;
        logic [NEST_W-1:0] nest;
        t_err              err;
    } t_result;

endpackage

/* rtl/bvs_step.sv */
// Per-byte parser step: next parser state and the result for one byte.
module bvs_step (
    input  bvs_pkg::t_state            i_state,
    input  logic [bvs_pkg::BYTE_W-1:0] i_data_byte,
    output bvs_pkg::t_state            o_state,
    output bvs_pkg::t_result           o_result
);
    import bvs_pkg::*;

    logic                 is_dec;
    logic [3:0]           digit;
    logic [LEN_WIDTH+3:0] acc_ext;
    logic [LEN_WIDTH+3:0] acc_next;
    logic                 len_ovf;
    logic [LEN_WIDTH-1:0] left_dec;
    t_state               nxt;
    logic                 done;
    t_role                role;
    t_err                 err;

    assign is_dec   = i_data_byte inside {[CHR_ZERO:CHR_NINE]};
    assign digit    = 4'(i_data_byte - CHR_ZERO);
    assign acc_ext  = (LEN_WIDTH+4)'(i_state.accum);
    // Ten times the accumulator plus the digit, built from two shifts.
    assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (LEN_WIDTH+4)'(digit);
    assign len_ovf  = |acc_next[LEN_WIDTH+3:LEN_WIDTH];
    assign left_dec = (i_state.left != '0) ? i_state.left - 1'b1 : i_state.left;

    always_comb begin
        nxt  = i_state;
        done = 1'b0;
        role = ROLE_OPENER;
        err  = ERR_NONE;
        case (i_state.mode)
            MODE_IDLE: begin
                nxt.depth = DEPTH_W'(1);
                nxt.mode  = MODE_ITEM;
            end
            MODE_LEN: begin
                if (is_dec) begin
                    role = ROLE_DIGIT;
                    if (len_ovf) begin
                        nxt.accum = LEN_MAX;
                        err       = ERR_LENGTH;
                    end else begin
                        nxt.accum = acc_next[LEN_WIDTH-1:0];
                    end
                end else begin
                    role      = ROLE_SEP;
                    nxt.left  = i_state.accum;
                    nxt.accum = '0;
                    nxt.mode  = (i_state.accum == '0) ? MODE_ITEM : MODE_STR;
                end
            end
            MODE_STR: begin
                role     = ROLE_STRING;
                nxt.left = left_dec;
                if (left_dec == '0) begin
                    nxt.mode = MODE_ITEM;
                end
            end
            MODE_INT: begin
                if (i_data_byte == CHR_NUL) begin
                    role      = ROLE_TERM;
                    err       = ERR_NUL_INT;
                    done      = 1'b1;
                    nxt.depth = '0;
                    nxt.mode  = MODE_IDLE;
                end else begin
                    role = ROLE_INT;
                    if (i_data_byte == CHR_E) begin
                        nxt.mode = MODE_ITEM;
                    end
                end
            end
            default: begin
                // Item position; an unused mode code behaves the same way.
                nxt.mode = MODE_ITEM;
                if (is_dec) begin
                    role      = ROLE_DIGIT;
                    nxt.accum = LEN_WIDTH'(digit);
                    nxt.mode  = MODE_LEN;
                end else if (i_data_byte == CHR_I) begin
                    role     = ROLE_INT;
                    nxt.mode = MODE_INT;
                end else if (i_data_byte == CHR_E) begin
                    role = ROLE_CLOSER;
                    if (i_state.depth <= DEPTH_W'(1)) begin
                        nxt.depth = '0;
                        done      = 1'b1;
                        nxt.mode  = MODE_IDLE;
                    end else begin
                        nxt.depth = i_state.depth - 1'b1;
                    end
                end else if (i_data_byte == CHR_NUL) begin
                    role      = ROLE_TERM;
                    done      = 1'b1;
                    nxt.depth = '0;
                    nxt.mode  = MODE_IDLE;
                end else begin
                    // Any other byte, 'l' and 'd' among them, opens a container.
                    role = ROLE_OPENER;
                    if (i_state.depth >= DEPTH_W'(MAX_DEPTH)) begin
                        err = ERR_DEPTH;
                    end else begin
                        nxt.depth = i_state.depth + 1'b1;
                    end
                end
            end
        endcase
    end

    assign o_state         = nxt;
    assign o_result.done   = done;
    assign o_result.role   = role;
    assign o_result.nest   = NEST_W'(nxt.depth);
    assign o_result.err    = err;

endmodule

/* rtl/bencode_value_skipper_top.sv */
// Top level of the bencode value skipper: input register, step logic, result register.
// A byte waits in the input register until the result register can take its result.
// Throughput: one byte per cycle; o_ready is low only while both stages are full and
// i_ready is low.
// Reset (i_rst_n low, synchronous): parser idle awaiting a top-level opener,
// depth, length and countdown cleared, both pipeline stages empty.
module bencode_value_skipper_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bvs_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_value_done,
    output logic [2:0]                 o_byte_role,
    output logic [bvs_pkg::NEST_W-1:0] o_nest_depth,
    output logic [1:0]                 o_error_code
);
    import bvs_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_result           r_result;
    t_result           n_result;
    logic              advance;

    bvs_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // The buffered byte moves on when the result register is empty or being drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{mode: MODE_IDLE, depth: '0, accum: '0, left: '0};
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_value_done = r_result.done;
    assign o_byte_role  = r_result.role;
    assign o_nest_depth = r_result.nest;
    assign o_error_code = r_result.err;

endmodule

/* rtl/bvs_checker.sv */
// Port-level assertions for the bencode value skipper, bound to its top level.
module bvs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_value_done,
    input logic [2:0]                 o_byte_role,
    input logic [bvs_pkg::NEST_W-1:0] o_nest_depth,
    input logic [1:0]                 o_error_code
);
    import bvs_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_done) && $stable(o_byte_role)
            && $stable(o_nest_depth) && $stable(o_error_code))
        else $error("result changed while stalled");

    // The end of the top-level container always leaves no container open.
    a_done_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_value_done |-> o_nest_depth == '0)
        else $error("value done with open depth");

    // NUL inside an integer is reported as a terminator ending the value.
    a_nul_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == ERR_NUL_INT |-> o_byte_role == ROLE_TERM && o_value_done)
        else $error("NUL in integer not a terminator");

    // Depth overflow only on openers, length overflow only on digits.
    a_err_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error_code == ERR_DEPTH || o_error_code == ERR_LENGTH) |->
            (o_error_code == ERR_DEPTH && o_byte_role == ROLE_OPENER)
            || (o_error_code == ERR_LENGTH && o_byte_role == ROLE_DIGIT))
        else $error("error code on wrong byte role");

endmodule

bind bencode_value_skipper_top bvs_checker u_bvs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_value_done (o_value_done),
    .o_byte_role  (o_byte_role),
    .o_nest_depth (o_nest_depth),
    .o_error_code (o_error_code)
);

/* tb/bvs_tb_pkg.sv */
// Scoreboard for the bencode value skipper: byte-level parser prediction and result checking.
package bvs_tb_pkg;

    import bvs_pkg::*;

    function automatic bit is_num_char(logic [BYTE_W-1:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_NINE);
    endfunction

    class skip_scoreboard;

        t_mode       mode;
        int          depth;
        logic [63:0] len_acc;
        logic [63:0] str_left;
        t_result     expected_q[$];
        int          mismatches;
        int          results_seen;

        function new();
            mode         = MODE_IDLE;
            depth        = 0;
            len_acc      = '0;
            str_left     = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advances the parser by one accepted byte and queues the result it should give.
        function void note_byte(logic [BYTE_W-1:0] b);
            t_result     r;
            logic [63:0] d;
            logic [63:0] len_cap;
            r.done  = 1'b0;
            r.role  = ROLE_OPENER;
            r.err   = ERR_NONE;
            d       = 64'(b) - 64'(CHR_ZERO);
            len_cap = 64'(LEN_MAX);
            case (mode)
                MODE_IDLE: begin
                    depth = 1;
                    mode  = MODE_ITEM;
                end
                MODE_LEN: begin
                    if (is_num_char(b)) begin
                        r.role = ROLE_DIGIT;
                        if (len_acc > (len_cap - d) / 10) begin
                            len_acc = len_cap;
                            r.err   = ERR_LENGTH;
                        end else begin
                            len_acc = len_acc * 10 + d;
                        end
                    end else begin
                        // The separator is taken whatever its value.
                        r.role   = ROLE_SEP;
                        str_left = len_acc;
                        len_acc  = '0;
                        mode     = (str_left == 0) ? MODE_ITEM : MODE_STR;
                    end
                end
                MODE_STR: begin
                    r.role = ROLE_STRING;
                    if (str_left > 0) str_left--;
                    if (str_left == 0) mode = MODE_ITEM;
                end
                MODE_INT: begin
                    if (b == CHR_NUL) begin
                        r.role = ROLE_TERM;
                        r.err  = ERR_NUL_INT;
                        r.done = 1'b1;
                        depth  = 0;
                        mode   = MODE_IDLE;
                    end else begin
                        r.role = ROLE_INT;
                        if (b == CHR_E) mode = MODE_ITEM;
                    end
                end
                default: begin
                    mode = MODE_ITEM;
                    if (is_num_char(b)) begin
                        r.role  = ROLE_DIGIT;
                        len_acc = d;
                        mode    = MODE_LEN;
                    end else if (b == CHR_I) begin
                        r.role = ROLE_INT;
                        mode   = MODE_INT;
                    end else if (b == CHR_E) begin
                        r.role = ROLE_CLOSER;
                        if (depth > 0) depth--;
                        if (depth == 0) begin
                            r.done = 1'b1;
                            mode   = MODE_IDLE;
                        end
                    end else if (b == CHR_NUL) begin
                        r.role = ROLE_TERM;
                        r.done = 1'b1;
                        depth  = 0;
                        mode   = MODE_IDLE;
                    end else if (depth >= MAX_DEPTH) begin
                        r.err = ERR_DEPTH;
                    end else begin
                        depth++;
                    end
                end
            endcase
            r.nest = NEST_W'(depth);
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(logic done, logic [2:0] role, logic [NEST_W-1:0] nest,
                          logic [1:0] err);
            t_result w;
            if (expected_q.size() == 0) begin
                report_mismatch("result arrived with nothing outstanding");
            end else begin
                w = expected_q.pop_front();
                check_field("value_done", 8'(done), 8'(w.done));
                check_field("byte_role", 8'(role), 8'(w.role));
                check_field("nest_depth", 8'(nest), 8'(w.nest));
                check_field("error_code", 8'(err), 8'(w.err));
            end
            results_seen++;
        endtask

    endclass

endpackage

/* tb/tb_bencode_value_skipper_top.sv */
// Testbench top for the bencode value skipper: stimulus, handshakes and final verdict.
module tb_bencode_value_skipper_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bvs_pkg::*;
    import bvs_tb_pkg::*;

    localparam int              ITEMS     = 1150;
    localparam logic [BYTE_W-1:0] CHR_COLON = 8'h3a;
    localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CHR_D     = 8'h64;
    localparam logic [BYTE_W-1:0] CHR_X     = 8'h78;
    localparam logic [BYTE_W-1:0] CHR_FF    = 8'hff;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic              o_value_done;
    logic [2:0]        o_byte_role;
    logic [NEST_W-1:0] o_nest_depth;
    logic [1:0]        o_error_code;

    skip_scoreboard    sb = new();
    logic [BYTE_W-1:0] byte_stream[$];
    int                bytes_sent = 0;
    bit                idle_on    = 1'b1;
    bit                hold_req   = 1'b0;
    int                hold_left  = 0;

    bencode_value_skipper_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value_done (o_value_done),
        .o_byte_role  (o_byte_role),
        .o_nest_depth (o_nest_depth),
        .o_error_code (o_error_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_value_done, o_byte_role, o_nest_depth, o_error_code);
            if (i_valid && o_ready)
                sb.note_byte(i_data_byte);
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the pipeline backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= !idle_on || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("tb_bencode_value_skipper_top: errors");
        $finish;
    end

    task automatic send_byte(logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        foreach (byte_stream[k]) send_byte(byte_stream[k]);
        byte_stream.delete();
    endtask

    // The sender stops offering until every queued result has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_opener();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(1, 255));
        while (is_num_char(b) || b == CHR_I || b == CHR_E);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_container_opener();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CHR_L;
        if (r < 90) return CHR_D;
        return pick_opener();
    endfunction

    function automatic void push_decimal(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++) byte_stream.push_back(s[k]);
    endfunction

    function automatic void build_value(int lvl);
        int                len;
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, (lvl >= 4) ? 1 : 2))
            0: begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                if ($urandom_range(0, 9) == 0) byte_stream.push_back(CHR_ZERO);
                push_decimal(len);
                if ($urandom_range(0, 9) == 0) begin
                    do b = 8'($urandom_range(0, 255)); while (is_num_char(b));
                    byte_stream.push_back(b);
                end else begin
                    byte_stream.push_back(CHR_COLON);
                end
                repeat (len) byte_stream.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                byte_stream.push_back(CHR_I);
                if ($urandom_range(0, 3) == 0) byte_stream.push_back(CHR_MINUS);
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) < 8) begin
                        b = CHR_ZERO + 8'($urandom_range(0, 9));
                    end else begin
                        do b = 8'($urandom_range(1, 255)); while (b == CHR_E);
                    end
                    byte_stream.push_back(b);
                end
                byte_stream.push_back(CHR_E);
            end
            default: begin
                byte_stream.push_back(pick_container_opener());
                repeat ($urandom_range(0, 3)) build_value(lvl + 1);
                byte_stream.push_back(CHR_E);
            end
        endcase
    endfunction

    function automatic void build_record();
        if ($urandom_range(0, 9) < 8) byte_stream.push_back(pick_container_opener());
        else byte_stream.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) build_value(1);
        byte_stream.push_back(CHR_E);
    endfunction

    // Nesting past the depth limit; closers stop once the top level has ended.
    function automatic void build_deep_record();
        int n;
        n = $urandom_range(28, 36);
        byte_stream.push_back(pick_container_opener());
        repeat (n) byte_stream.push_back(CHR_L);
        repeat ((n + 1 < MAX_DEPTH) ? n + 1 : MAX_DEPTH) byte_stream.push_back(CHR_E);
    endfunction

    // Random bytes with no two digits in a row, so any string length stays small.
    function automatic void build_noise();
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] prev;
        prev = CHR_COLON;
        repeat ($urandom_range(1, 12)) begin
            b = 8'($urandom_range(0, 255));
            if (is_num_char(b) && is_num_char(prev)) b = CHR_COLON;
            byte_stream.push_back(b);
            prev = b;
        end
    endfunction

    // Steers the parser back to idle from whatever state broken input left it in.
    task automatic settle_parser();
        int n;
        forever begin
            wait_drained();
            if (sb.mode == MODE_IDLE) break;
            case (sb.mode)
                MODE_STR: begin
                    n = int'(sb.str_left);
                    repeat (n) send_byte(8'($urandom_range(0, 255)));
                end
                MODE_LEN: send_byte(CHR_COLON);
                MODE_INT: send_byte(CHR_E);
                default:  send_byte(CHR_NUL);
            endcase
        end
    endtask

    initial begin
        int wait_cnt;
        int r;
        int holds_done;
        string s;
        holds_done = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // NUL as a top-level opener, then NUL as a terminator.
        byte_stream = '{CHR_NUL, CHR_NUL};
        // Zero-length string, odd separator, NUL and 'e' inside a string, integer, empty list.
        byte_stream = {byte_stream, CHR_D, CHR_ZERO, CHR_COLON, 8'h33, CHR_X, CHR_NUL,
                       CHR_E, CHR_FF, CHR_I, CHR_MINUS, 8'h34, CHR_E, CHR_L, CHR_E, CHR_E};
        // NUL inside an integer ends everything.
        byte_stream = {byte_stream, CHR_FF, CHR_I, 8'h37, CHR_NUL};
        // A digit opens the top level just as any other byte does.
        byte_stream = {byte_stream, 8'h35, CHR_E};
        send_stream();
        wait_drained();

        while (bytes_sent < ITEMS) begin
            // Each long hold-off is requested once, whatever the record sizes are.
            if (holds_done == 0 && bytes_sent >= 200) begin
                hold_req   = 1'b1;
                holds_done = 1;
            end
            if (holds_done == 1 && bytes_sent >= 800) begin
                hold_req   = 1'b1;
                holds_done = 2;
            end
            idle_on = !(bytes_sent >= 450 && bytes_sent < 650);
            r = $urandom_range(0, 99);
            if (r < 78) begin
                build_record();
                send_stream();
            end else if (r < 86) begin
                build_deep_record();
                send_stream();
            end else if (r < 93) begin
                build_noise();
                send_stream();
                settle_parser();
            end else begin
                build_record();
                byte_stream = byte_stream[0:$urandom_range(0, byte_stream.size() - 1)];
                if ($urandom_range(0, 1) == 0) byte_stream.push_back(CHR_NUL);
                send_stream();
                settle_parser();
            end
        end
        idle_on = 1'b1;
        settle_parser();

        // Length saturation comes last: a saturated count keeps the parser in string
        // mode for the rest of the run.
        byte_stream.push_back(CHR_L);
        s = $sformatf("%0d", LEN_MAX);
        for (int k = 0; k < s.len(); k++) byte_stream.push_back(s[k]);
        byte_stream = {byte_stream, 8'h36, 8'h31, CHR_COLON, CHR_X, CHR_E};
        send_stream();

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_cnt = 0;
        while (sb.pending() != 0 && wait_cnt < 1000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        repeat (5) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_bencode_value_skipper_top: clean");
        end else begin
            $display("tb_bencode_value_skipper_top: errors");
        end
        $finish;
    end

endmodule

/* bencode_value_skipper_top.f */
rtl/bvs_pkg.sv
rtl/bvs_step.sv
rtl/bencode_value_skipper_top.sv
rtl/bvs_checker.sv
tb/bvs_tb_pkg.sv
tb/tb_bencode_value_skipper_top.sv
